// ===== rtl/core/wia_pkg.sv =====
`default_nettype none
package wia_pkg;

  localparam int DIGIT_BITS  = 32;
  localparam int DIGIT_COUNT = 16;
  localparam int IDX_BITS    = 4;
  localparam int HALF        = DIGIT_COUNT / 2;
  localparam int TOTAL_BITS  = DIGIT_BITS * DIGIT_COUNT;
  localparam int BIT_CNT_W   = 9;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [BIT_CNT_W-1:0]  bcnt_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_SHL = 4'd4,
    OP_SHR = 4'd5,
    OP_AND = 4'd6,
    OP_OR  = 4'd7,
    OP_CMP = 4'd8
  } op_t;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;        // write digit pair
    logic  start;       // clear work registers, latch op
    logic  digit_step;  // process digit at cnt (add/sub/logic/shift/cmp/zero check)
    logic  mul_step;    // one partial product at (i,j)
    logic  mul_row_end; // store row carry
    logic  div_shift;   // shift in next dividend bit
    logic  div_sub;     // conditional subtract digit at cnt
    logic  div_end;     // commit subtract decision
    idx_t  i;
    idx_t  j;
    idx_t  cnt;
    bcnt_t bit_pos;
  } dp_cmd_t;

  typedef struct packed {
    logic       b_zero;
    logic [1:0] cmp;
    logic       carry;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/wia_datapath.sv =====
`default_nettype none
module wia_datapath (
  input  wire logic                clk,
  input  wire wia_pkg::dp_cmd_t    cmd,
  input  wire wia_pkg::idx_t       ld_index,
  input  wire wia_pkg::digit_t     ld_a,
  input  wire wia_pkg::digit_t     ld_b,
  input  wire wia_pkg::op_t        op,
  input  wire logic [8:0]          shamt,
  input  wire logic                rd_rem,
  input  wire wia_pkg::idx_t       rd_index,
  output wia_pkg::digit_t          rd_digit,
  output wia_pkg::dp_stat_t        stat,
  input  wire logic                rst
);
  localparam int DB = wia_pkg::DIGIT_BITS;
  localparam int ND = wia_pkg::DIGIT_COUNT;

  wia_pkg::digit_t opa [ND];
  wia_pkg::digit_t opb [ND];
  wia_pkg::digit_t res [ND];
  wia_pkg::digit_t quo [ND];
  wia_pkg::digit_t dif [ND];
  logic            carry;
  logic            top;
  logic [1:0]      cmp;
  logic            b_zero;
  logic [8:0]      shamt_q;

  // Shift decomposition
  logic [8:0]    ds_full;
  logic [4:0]    bs;
  logic [9:0]    src_lo, src_hi;
  wia_pkg::digit_t sa, sb;
  logic [2*DB-1:0] win;
  wia_pkg::digit_t sh_digit;

  assign ds_full = {5'd0, shamt_q[8:5]};
  assign bs      = shamt_q[4:0];

  always_comb begin
    src_lo = '0;
    src_hi = '0;
    sa     = '0;
    sb     = '0;
    if (op == wia_pkg::OP_SHL) begin
      // pair {a[s], a[s-1]}
      src_hi = 10'({6'd0, cmd.cnt}) - 10'(ds_full);
      src_lo = src_hi - 10'd1;
    end else begin
      src_lo = 10'({6'd0, cmd.cnt}) + 10'(ds_full);
      src_hi = src_lo + 10'd1;
    end
    if (src_hi < 10'(ND)) sa = opa[src_hi[wia_pkg::IDX_BITS-1:0]];
    if (src_lo < 10'(ND)) sb = opa[src_lo[wia_pkg::IDX_BITS-1:0]];
    win = {sa, sb};
    if (op == wia_pkg::OP_SHL) sh_digit = DB'((win << bs) >> DB);
    else                        sh_digit = DB'(win >> bs);
  end

  // Digit-serial add/sub
  logic [DB:0] addsub;
  always_comb begin
    if (op == wia_pkg::OP_ADD)
      addsub = {1'b0, opa[cmd.cnt]} + {1'b0, opb[cmd.cnt]} + (DB+1)'(carry);
    else
      addsub = {1'b0, opa[cmd.cnt]} - {1'b0, opb[cmd.cnt]} - (DB+1)'(carry);
  end

  // Division subtract: res - b digit
  logic [DB:0] dsub;
  assign dsub = {1'b0, res[cmd.cnt]} - {1'b0, opb[cmd.cnt]} - (DB+1)'(carry);

  // Multiply accumulate: a[j]*b[i] + res[i+j] + carry (carry held in mcar)
  wia_pkg::digit_t mcar;
  logic [2*DB-1:0] prod_q;
  logic [2*DB:0]   mac;
  wia_pkg::idx_t   ij;
  assign ij  = cmd.i + cmd.j;
  assign mac = (2*DB+1)'(prod_q) + (2*DB+1)'(res[ij]) + (2*DB+1)'(mcar);

  // Multiplier register pipeline: product registered each cycle
  always_ff @(posedge clk) begin
    prod_q <= opa[cmd.j] * opb[cmd.i];
  end

  // Division does not use the cmp tracking: the subtract borrow and the top
  // bit shifted out decide, res >= b iff top is set or there is no borrow.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ND; k++) begin
        opa[k] <= '0;
        opb[k] <= '0;
      end
    end else if (cmd.load) begin
      opa[ld_index] <= ld_a;
      opb[ld_index] <= ld_b;
    end
    if (cmd.start) begin
      for (int k = 0; k < ND; k++) begin
        res[k] <= '0;
        quo[k] <= '0;
      end
      carry   <= 1'b0;
      cmp     <= wia_pkg::CMP_EQ;
      b_zero  <= 1'b1;
      mcar    <= '0;
      top     <= 1'b0;
      shamt_q <= shamt;
    end
    if (cmd.digit_step) begin
      if (opb[cmd.cnt] != '0) b_zero <= 1'b0;
      if (opa[cmd.cnt] < opb[cmd.cnt]) cmp <= wia_pkg::CMP_LT;
      else if (opa[cmd.cnt] > opb[cmd.cnt]) cmp <= wia_pkg::CMP_GT;
      unique case (op)
        wia_pkg::OP_ADD, wia_pkg::OP_SUB: begin
          res[cmd.cnt] <= addsub[DB-1:0];
          carry        <= addsub[DB];
        end
        wia_pkg::OP_SHL, wia_pkg::OP_SHR:
          res[cmd.cnt] <= sh_digit;
        wia_pkg::OP_AND: res[cmd.cnt] <= opa[cmd.cnt] & opb[cmd.cnt];
        wia_pkg::OP_OR:  res[cmd.cnt] <= opa[cmd.cnt] | opb[cmd.cnt];
        default: ;
      endcase
    end
    if (cmd.mul_step) begin
      res[ij] <= mac[DB-1:0];
      mcar    <= mac[2*DB-1:DB];
    end
    if (cmd.mul_row_end) begin
      res[cmd.i + wia_pkg::idx_t'(wia_pkg::HALF)] <= mcar;
      mcar <= '0;
    end
    if (cmd.div_shift) begin
      top    <= res[ND-1][DB-1];
      res[0] <= {res[0][DB-2:0], opa[cmd.bit_pos[8:5]][cmd.bit_pos[4:0]]};
      for (int k = 1; k < ND; k++) res[k] <= {res[k][DB-2:0], res[k-1][DB-1]};
      carry  <= 1'b0;
    end
    if (cmd.div_sub) begin
      dif[cmd.cnt] <= dsub[DB-1:0];
      carry        <= dsub[DB];
    end
    if (cmd.div_end) begin
      if (top || !carry) begin
        for (int k = 0; k < ND; k++) res[k] <= dif[k];
        quo[cmd.bit_pos[8:5]][cmd.bit_pos[4:0]] <= 1'b1;
      end
    end
  end

  assign rd_digit    = rd_rem ? res[rd_index] : (op == wia_pkg::OP_DIV ? quo[rd_index]
                                                                       : res[rd_index]);
  assign stat.b_zero = b_zero;
  assign stat.cmp    = cmp;
  assign stat.carry  = carry;
endmodule
`default_nettype wire

// ===== rtl/core/wia_ctrl.sv =====
`default_nettype none
module wia_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              in_exec,
  input  wire wia_pkg::idx_t     in_index,
  input  wire logic [3:0]        in_op,
  output logic                   in_ready,
  output wia_pkg::op_t           op,
  output wia_pkg::dp_cmd_t       cmd,
  input  wire wia_pkg::dp_stat_t stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_rem,
  output wia_pkg::idx_t          out_idx,
  output logic                   out_carry,
  output logic                   out_borrow,
  output logic [1:0]             out_cmp,
  output logic                   out_dz,
  output logic                   out_last
);
  localparam int ND = wia_pkg::DIGIT_COUNT;
  localparam wia_pkg::idx_t IDX_MAX = wia_pkg::idx_t'(ND - 1);
  localparam wia_pkg::idx_t HMAX    = wia_pkg::idx_t'(wia_pkg::HALF - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_MUL_P, S_MUL, S_ROW, S_DSHIFT, S_DSUB, S_DEND, S_EMIT
  } state_t;

  state_t        state;
  wia_pkg::idx_t cnt, mi, mj;
  wia_pkg::bcnt_t bitp;
  logic          emit_rem;

  assign in_ready = (state == S_IDLE);
  assign out_rem  = emit_rem;

  always_comb begin
    cmd.cnt         = cnt;
    cmd.i           = mi;
    cmd.j           = mj;
    cmd.bit_pos     = bitp;
    cmd.load        = in_fire && !in_exec && (32'(in_index) < ND);
    cmd.start       = in_fire && in_exec;
    cmd.digit_step  = (state == S_SCAN);
    cmd.mul_step    = (state == S_MUL);
    cmd.mul_row_end = (state == S_ROW);
    cmd.div_shift   = (state == S_DSHIFT);
    cmd.div_sub     = (state == S_DSUB);
    cmd.div_end     = (state == S_DEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op        <= wia_pkg::OP_ADD;
      cnt       <= '0;
      mi        <= '0;
      mj        <= '0;
      bitp      <= '0;
      emit_rem  <= 1'b0;
      out_idx   <= '0;
      out_carry <= 1'b0;
      out_borrow <= 1'b0;
      out_cmp   <= '0;
      out_dz    <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_exec && in_op <= 4'(wia_pkg::OP_CMP)) begin
            op       <= wia_pkg::op_t'(in_op);
            cnt      <= '0;
            mi       <= '0;
            mj       <= '0;
            emit_rem <= 1'b0;
            state    <= (in_op == 4'(wia_pkg::OP_MUL)) ? S_MUL_P : S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_MAX) begin
            cnt <= '0;
            if (op == wia_pkg::OP_DIV) begin
              bitp  <= wia_pkg::bcnt_t'(wia_pkg::TOTAL_BITS - 1);
              state <= S_DSHIFT;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_MUL_P: state <= S_MUL;
        S_MUL: begin
          mj    <= mj + 1'b1;
          state <= S_MUL_P;
          if (mj == HMAX) begin
            mj    <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          mi    <= mi + 1'b1;
          state <= S_MUL_P;
          if (mi == HMAX) begin
            cnt   <= '0;
            state <= S_EMIT;
          end
        end
        S_DSHIFT: begin
          if (stat.b_zero) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt   <= '0;
            state <= S_DSUB;
          end
        end
        S_DSUB: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_MAX) state <= S_DEND;
        end
        S_DEND: begin
          bitp  <= bitp - 1'b1;
          cnt   <= '0;
          state <= (bitp == '0) ? S_EMIT : S_DSHIFT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_idx   <= cnt;
              out_dz    <= (op == wia_pkg::OP_DIV) && stat.b_zero;
              out_cmp   <= (op == wia_pkg::OP_CMP) ? stat.cmp : wia_pkg::CMP_LT;
              out_last  <= (op == wia_pkg::OP_CMP) ||
                           (cnt == IDX_MAX && (op != wia_pkg::OP_DIV || emit_rem));
              out_carry <= (op == wia_pkg::OP_ADD) && cnt == IDX_MAX && stat.carry;
              out_borrow <= (op == wia_pkg::OP_SUB) && cnt == IDX_MAX && stat.carry;
              cnt       <= cnt + 1'b1;
              // remainder digits follow the top quotient digit
              if (op == wia_pkg::OP_DIV && cnt == IDX_MAX) emit_rem <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/wide_integer_alu.sv =====
// Channel | Direction | tdata fields (low first)                           | tuser
// s_axis  | in        | digit_index, a_digit, b_digit, op_code, shift      | req_type
// m_axis  | out       | result_digit, out_index, carry, borrow, cmp,       | is_remainder
//         |           | divide_by_zero                                     | tlast = last
// A load writes one digit pair. Add, sub, logic, shift and compare scan 16
// digits, then emit 16 digits at one per cycle unless m_axis_tready stalls
// (compare emits one). Multiply uses one registered 32x32 multiplier: 64
// partial products, each registered then accumulated, plus a row-end step
// per row, then 16 digits. Divide scans 16 digits, then runs 512 bit steps
// of shift, subtract and commit (skipped when B is zero), then 32 digits.
// rst is synchronous and clears operands; m_axis_tready stalls emission only.
`default_nettype none
module wide_integer_alu (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // digit_index[3:0], a_digit[35:4], b_digit[67:36], op_code[71:68],
  // shift_amount[80:72], zero pad to 88
  input  wire logic [87:0]  s_axis_tdata,
  // req_type
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_digit[31:0], out_index[35:32], carry_out[36], borrow_out[37],
  // compare_result[39:38], divide_by_zero[40], zero pad to 48
  output logic [47:0]       m_axis_tdata,
  // is_remainder
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);
  wia_pkg::dp_cmd_t  cmd;
  wia_pkg::dp_stat_t stat;
  wia_pkg::op_t      op;
  wia_pkg::idx_t     out_idx;
  wia_pkg::digit_t   rd_digit;
  wia_pkg::digit_t   digit_q;
  logic carry, borrow, dz, rem, fire;
  logic [1:0] cmpv;

  assign fire = s_axis_tvalid && s_axis_tready;

  wia_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(fire), .in_exec(s_axis_tuser),
    .in_index(s_axis_tdata[3:0]), .in_op(s_axis_tdata[71:68]),
    .in_ready(s_axis_tready), .op(op), .cmd(cmd), .stat(stat),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rem(rem),
    .out_idx(out_idx), .out_carry(carry), .out_borrow(borrow),
    .out_cmp(cmpv), .out_dz(dz), .out_last(m_axis_tlast)
  );

  wia_datapath u_dp (
    .clk(clk), .cmd(cmd), .ld_index(s_axis_tdata[3:0]),
    .ld_a(s_axis_tdata[35:4]), .ld_b(s_axis_tdata[67:36]), .op(op),
    .shamt(s_axis_tdata[80:72]), .rd_rem(rem), .rd_index(cmd.cnt),
    .rd_digit(rd_digit), .stat(stat), .rst(rst)
  );

  // Digit and remainder flag registers follow the index register load
  logic rem_q;
  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      digit_q <= (op == wia_pkg::OP_CMP || (op == wia_pkg::OP_DIV && stat.b_zero))
                 ? '0 : rd_digit;
      rem_q   <= rem;
    end
  end

  assign m_axis_tuser = rem_q;
  assign m_axis_tdata = {7'd0, dz, cmpv, borrow, carry, out_idx, digit_q};
endmodule
`default_nettype wire
